/* rtl/command_line_tokenizer_top_macros.svh */
// Assertion macros shared by the tokenizer RTL.
// Depends on clk_i and rst_ni being present in the module that uses them.
`ifndef COMMAND_LINE_TOKENIZER_TOP_MACROS_SVH
`define COMMAND_LINE_TOKENIZER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define CLT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("clt assertion failed");
`define CLT_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);
`else
`define CLT_ASSERT(lbl, prop)
`define CLT_ASSERT_MSG(lbl, prop, msg)
`endif

`endif

/* rtl/clt_pkg.sv */
// Types and constants of the command line tokenizer.
// No dependencies; used by every module of the block.
package clt_pkg;

  localparam int unsigned MaxResults = 3;
  localparam logic [7:0] MaxLenReset = 8'd100;
  localparam logic [8:0] CountMax = 9'd511;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChOpen = 8'h28;
  localparam logic [7:0] ChClose = 8'h29;

  localparam logic [1:0] KindByte = 2'd0;
  localparam logic [1:0] KindEnd = 2'd1;
  localparam logic [1:0] KindAccept = 2'd2;
  localparam logic [1:0] KindReject = 2'd3;

  localparam logic [2:0] ErrTooLong = 3'd0;
  localparam logic [2:0] ErrQuoteInParens = 3'd1;
  localparam logic [2:0] ErrEmptyQuotes = 3'd2;
  localparam logic [2:0] ErrNestedParen = 3'd3;
  localparam logic [2:0] ErrEmptyParens = 3'd4;

  typedef struct packed {
    logic [7:0] char_in;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] token_byte;
    logic [2:0] error_code;
    logic       last_result;
  } out_t;

  typedef out_t [MaxResults-1:0] group_t;

  typedef struct packed {
    logic       in_quotes;
    logic       in_parens;
    logic       token_open;
    logic [8:0] byte_count;
    logic       error_latched;
    logic [2:0] first_error;
  } st_t;

endpackage

/* rtl/clt_step.sv */
// Per-byte tokenizer step: next command state and up to three results.
// Depends on clt_pkg.
module clt_step (
  input  clt_pkg::st_t    state_i,
  input  clt_pkg::in_t    in_i,
  input  logic [7:0]      max_len_i,
  output clt_pkg::st_t    state_o,
  output clt_pkg::group_t res_o,
  output logic [1:0]      cnt_o
);
  import clt_pkg::*;

  always_comb begin
    st_t        st;
    group_t     res;
    logic [1:0] n;
    logic [7:0] c;
    logic       too_long;
    st = state_i;
    res = '0;
    n = 2'd0;
    c = in_i.char_in;
    too_long = 1'b0;
    if (st.byte_count < CountMax) begin
      st.byte_count = st.byte_count + 9'd1;
    end
    if (!st.error_latched) begin
      if (c == ChSpace && !st.in_quotes && !st.in_parens) begin
        if (st.token_open) begin
          res[n] = '{KindEnd, 8'd0, ErrTooLong, 1'b0};
          n = n + 2'd1;
        end
        st.token_open = 1'b0;
      end else if (c == ChQuote) begin
        if (st.in_parens) begin
          st.error_latched = 1'b1;
          st.first_error = ErrQuoteInParens;
        end else if (st.in_quotes) begin
          if (!st.token_open) begin
            st.error_latched = 1'b1;
            st.first_error = ErrEmptyQuotes;
          end else begin
            st.in_quotes = 1'b0;
            res[n] = '{KindEnd, 8'd0, ErrTooLong, 1'b0};
            n = n + 2'd1;
            st.token_open = 1'b0;
          end
        end else begin
          if (st.token_open) begin
            res[n] = '{KindEnd, 8'd0, ErrTooLong, 1'b0};
            n = n + 2'd1;
          end
          st.token_open = 1'b0;
          st.in_quotes = 1'b1;
        end
      end else if (c == ChOpen) begin
        if (st.in_quotes) begin
          res[n] = '{KindByte, c, ErrTooLong, 1'b0};
          n = n + 2'd1;
          st.token_open = 1'b1;
        end else if (st.in_parens) begin
          st.error_latched = 1'b1;
          st.first_error = ErrNestedParen;
        end else begin
          if (st.token_open) begin
            res[n] = '{KindEnd, 8'd0, ErrTooLong, 1'b0};
            n = n + 2'd1;
          end
          st.token_open = 1'b0;
          st.in_parens = 1'b1;
        end
      end else if (c == ChClose) begin
        if (st.in_quotes) begin
          res[n] = '{KindByte, c, ErrTooLong, 1'b0};
          n = n + 2'd1;
          st.token_open = 1'b1;
        end else if (st.in_parens) begin
          if (!st.token_open) begin
            st.error_latched = 1'b1;
            st.first_error = ErrEmptyParens;
          end else begin
            res[n] = '{KindEnd, 8'd0, ErrTooLong, 1'b0};
            n = n + 2'd1;
            st.token_open = 1'b0;
            st.in_parens = 1'b0;
          end
        end
      end else begin
        res[n] = '{KindByte, c, ErrTooLong, 1'b0};
        n = n + 2'd1;
        st.token_open = 1'b1;
      end
    end
    if (in_i.last_char) begin
      too_long = st.byte_count > {1'b0, max_len_i};
      if (!st.error_latched && st.token_open) begin
        res[n] = '{KindEnd, 8'd0, ErrTooLong, 1'b0};
        n = n + 2'd1;
      end
      if (too_long) begin
        res[n] = '{KindReject, 8'd0, ErrTooLong, 1'b1};
      end else if (st.error_latched) begin
        res[n] = '{KindReject, 8'd0, st.first_error, 1'b1};
      end else begin
        res[n] = '{KindAccept, 8'd0, ErrTooLong, 1'b1};
      end
      n = n + 2'd1;
      st = '0;
    end
    state_o = st;
    res_o = res;
    cnt_o = n;
  end

endmodule

/* rtl/clt_result_buf.sv */
// Result group register: holds the results of one byte and sends them one per cycle
// while out_stall_i is low. Depends on clt_pkg and the assertion macro header.
`include "command_line_tokenizer_top_macros.svh"
module clt_result_buf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  clt_pkg::group_t group_i,
  input  logic [1:0]      cnt_i,
  output logic            ready_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output clt_pkg::out_t   out_data_o
);
  import clt_pkg::*;

  group_t     group_q, group_d;
  logic [1:0] head_q, head_d;
  logic [1:0] rem_q, rem_d;
  logic       pop;

  assign out_valid_o = (rem_q != 2'd0);
  assign pop = out_valid_o && !out_stall_i;
  assign ready_o = (rem_q == 2'd0) || (rem_q == 2'd1 && pop);
  assign out_data_o = group_q[head_q];

  always_comb begin
    group_d = group_q;
    head_d = head_q;
    rem_d = rem_q;
    if (pop) begin
      head_d = head_q + 2'd1;
      rem_d = rem_q - 2'd1;
    end
    if (load_i) begin
      group_d = group_i;
      head_d = 2'd0;
      rem_d = cnt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= 2'd0;
      rem_q <= 2'd0;
    end else begin
      head_q <= head_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    group_q <= group_d;
  end

  `CLT_ASSERT(a_slot_range, out_valid_o |-> ({1'b0, head_q} + {1'b0, rem_q} <= 3'd3))
  `CLT_ASSERT(a_final_last, (out_valid_o && out_data_o.last_result) |-> (rem_q == 2'd1))
  `CLT_ASSERT_MSG(a_no_overwrite, load_i |-> ready_o, "group overwritten before drained")

endmodule

/* rtl/command_line_tokenizer_top.sv */
// Top level of the command line tokenizer: config register, command state, result buffer.
// Depends on clt_pkg, clt_step, clt_result_buf and the assertion macro header.
//
// One command byte is taken per transfer and may cause zero to three results
// (token byte, token end, accept or reject). A new byte is taken in every cycle
// as long as each byte leaves at most one result; a byte that leaves more results
// stalls the input while the result register sends them one per cycle, and a
// stall on the result side holds the input as well. State updates are computed
// by combinational logic ahead of the result register. max_length may only be
// written while no command byte is in flight.
`include "command_line_tokenizer_top_macros.svh"
module command_line_tokenizer_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [7:0]    cfg_wdata_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  clt_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output clt_pkg::out_t out_data_o
);
  import clt_pkg::*;

  logic [7:0] max_len_q;
  st_t        st_q, st_d;
  group_t     group;
  logic [1:0] cnt;
  logic       ready;
  logic       accept;

  assign in_stall_o = !ready;
  assign accept = in_valid_i && ready;

  clt_step u_step (
    .state_i   (st_q),
    .in_i      (in_data_i),
    .max_len_i (max_len_q),
    .state_o   (st_d),
    .res_o     (group),
    .cnt_o     (cnt)
  );

  clt_result_buf u_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .group_i     (group),
    .cnt_i       (cnt),
    .ready_o     (ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenReset;
      st_q <= '0;
    end else begin
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
      if (accept) begin
        st_q <= st_d;
      end
    end
  end

  `CLT_ASSERT(a_clear_after_last, (accept && in_data_i.last_char) |=> (st_q.byte_count == 9'd0))
  `CLT_ASSERT(a_err_code_clear, !st_q.error_latched |-> (st_q.first_error == ErrTooLong))
  `CLT_ASSERT(a_fresh_state, (st_q.byte_count == 9'd0) |-> (!st_q.token_open && !st_q.error_latched))

endmodule
